@@ sv/sacl_pkg.sv @@
// Package: cache controller geometry, opcodes and field widths.
package sacl_pkg;
   localparam int SET_BITS  = 6;
   localparam int WAY_BITS  = 2;
   localparam int NUM_SETS  = 1 << SET_BITS;
   localparam int NUM_WAYS  = 1 << WAY_BITS;
   localparam int TAG_W     = 32;
   localparam int ROW_W     = NUM_WAYS * (TAG_W + WAY_BITS);
   localparam logic [4:0] OFF_MAX = 5'd16;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_INVAL = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic CSR_OFFSET_BITS    = 1'b0;
   localparam logic CSR_WRITE_ALLOCATE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;
endpackage

@@ sv/set_assoc_cache_lru_ctrl.sv @@
// Top level: tag/state controller of a set-associative write-back cache with true LRU.
//
//   channel | direction | tdata / tuser content
//   req     | in        | tdata: opcode[1:0], address[33:2], zero pad to 40 bits
//   rsp     | out       | tdata: hit, hit_way, fill_request, forward_write,
//           |           |        writeback_valid, writeback_address,
//           |           |        back_invalidate_valid, back_invalidate_address
//   csr     | in        | index 0 offset_bits, index 1 write_allocate
//
// The set row is read from memory at the edge that takes a request beat; at the
// next edge the row is compared, updated and written back and the result beat is
// registered. The next request is taken only after that result beat has left.
// Tags are kept as 32-bit address remainders, so any offset_bits up to 16 works;
// larger values are clamped to 16.
// After reset a clearing pass runs over all NUM_SETS rows, one a cycle, while no
// request is taken. A stalled result holds the next request.
// Valid bits, dirty bits, tags and ranks all live in the row memory.
module set_assoc_cache_lru_ctrl (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // opcode[1:0], address[33:2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // hit[0], hit_way[2:1], fill_request[3],
                                    // forward_write[4], writeback_valid[5],
                                    // writeback_address[37:6],
                                    // back_invalidate_valid[38],
                                    // back_invalidate_address[70:39], pad[71]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [4:0]  csr_data
);
   localparam int NW = sacl_pkg::NUM_WAYS;
   localparam int WB = sacl_pkg::WAY_BITS;
   localparam int SB = sacl_pkg::SET_BITS;
   localparam int TW = sacl_pkg::TAG_W;

   // row memory: valid, dirty, tags and ranks for all ways of one set
   logic [TW-1:0] tag_mem  [sacl_pkg::NUM_SETS][NW];
   logic [WB-1:0] rank_mem [sacl_pkg::NUM_SETS][NW];
   logic [NW-1:0] valid_mem [sacl_pkg::NUM_SETS];
   logic [NW-1:0] dirty_mem [sacl_pkg::NUM_SETS];
   logic [TW-1:0] tag_rd   [NW];
   logic [WB-1:0] rank_rd  [NW];
   logic [TW-1:0] tag_wr   [NW];
   logic [WB-1:0] rank_wr  [NW];
   logic [NW-1:0] valid_rd, dirty_rd, valid_wr, dirty_wr;
   logic          mem_we;
   logic [SB-1:0] wr_set;
   logic [SB-1:0] rd_set;

   sacl_pkg::state_type state_ff, state_in;
   logic [SB:0]   clr_ff, clr_in;
   logic [4:0]    off_ff;
   logic          walloc_ff;
   logic [1:0]    op_ff;
   logic [31:0]   addr_ff;
   logic [4:0]    offc_ff;
   logic          rsp_valid_ff;
   logic [70:0]   rsp_ff;

   logic [4:0]    off_now;
   logic [31:0]   req_addr;
   logic          req_fire;

   assign off_now  = (off_ff > sacl_pkg::OFF_MAX) ? sacl_pkg::OFF_MAX : off_ff;
   assign req_addr = req_tdata[33:2];
   assign req_fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == sacl_pkg::ST_IDLE) && !rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff};
   assign rd_set = SB'(req_addr >> off_now);

   // memory: synchronous read, one write port
   always_ff @(posedge clock) begin
      for (int w = 0; w < NW; w++) begin
         tag_rd[w]  <= tag_mem[rd_set][w];
         rank_rd[w] <= rank_mem[rd_set][w];
         if (mem_we) begin
            tag_mem[wr_set][w]  <= tag_wr[w];
            rank_mem[wr_set][w] <= rank_wr[w];
         end
      end
      valid_rd <= valid_mem[rd_set];
      dirty_rd <= dirty_mem[rd_set];
      if (mem_we) begin
         valid_mem[wr_set] <= valid_wr;
         dirty_mem[wr_set] <= dirty_wr;
      end
   end

   // execute stage
   logic [SB-1:0] e_set;
   logic [TW-1:0] e_tag;
   logic [NW-1:0] vrow, drow, vrow_n, drow_n;
   logic          found, victim_found, valid_v, dirty_v, alloc;
   logic [WB-1:0] way, victim, tway;
   logic [31:0]   vaddr;
   logic [70:0]   res;

   always_comb begin
      e_set  = SB'(addr_ff >> offc_ff);
      e_tag  = TW'(addr_ff >> (offc_ff + 5'(SB)));
      vrow   = valid_rd;
      drow   = dirty_rd;
      vrow_n = vrow;
      drow_n = drow;
      found  = 1'b0;
      way    = '0;
      for (int w = NW - 1; w >= 0; w--) begin
         if (vrow[w] && tag_rd[w] == e_tag) begin
            found = 1'b1;
            way   = WB'(w);
         end
      end
      victim_found = 1'b0;
      victim = '0;
      for (int w = NW - 1; w >= 0; w--) begin
         if (!vrow[w]) begin
            victim_found = 1'b1;
            victim = WB'(w);
         end
      end
      if (!victim_found) begin
         for (int w = NW - 1; w >= 0; w--) begin
            if (rank_rd[w] == '0) begin
               victim = WB'(w);
            end
         end
      end
      valid_v = vrow[victim];
      dirty_v = drow[victim];
      vaddr   = 32'(({32'd0, tag_rd[victim]} << (offc_ff + 5'(SB)))
                | ({58'd0, e_set} << offc_ff));
      res     = '0;
      alloc   = 1'b0;
      tway    = way;
      mem_we  = 1'b0;
      for (int w = 0; w < NW; w++) begin
         tag_wr[w]  = tag_rd[w];
         rank_wr[w] = rank_rd[w];
      end
      case (sacl_pkg::op_type'(op_ff))
         sacl_pkg::OP_INVAL: begin
            if (found) begin
               mem_we = 1'b1;
               vrow_n[way] = 1'b0;
               drow_n[way] = 1'b0;
               res[0] = 1'b1;
               res[2:1] = way;
            end
         end
         sacl_pkg::OP_READ, sacl_pkg::OP_WRITE: begin
            if (found) begin
               mem_we = 1'b1;
               if (op_ff == sacl_pkg::OP_WRITE) drow_n[way] = 1'b1;
               res[0] = 1'b1;
               res[2:1] = way;
            end else if (op_ff == sacl_pkg::OP_WRITE && !walloc_ff) begin
               res[4] = 1'b1;
            end else begin
               alloc  = 1'b1;
               mem_we = 1'b1;
               tway   = victim;
               vrow_n[victim] = 1'b1;
               drow_n[victim] = (op_ff == sacl_pkg::OP_WRITE);
               tag_wr[victim] = e_tag;
               res[2:1] = victim;
               res[3] = 1'b1;
               if (valid_v) begin
                  res[38] = 1'b1;
                  res[70:39] = vaddr;
                  if (dirty_v) begin
                     res[5] = 1'b1;
                     res[37:6] = vaddr;
                  end
               end
            end
            if (mem_we) begin
               for (int w = 0; w < NW; w++) begin
                  if (WB'(w) != tway && rank_rd[w] > rank_rd[tway])
                     rank_wr[w] = rank_rd[w] - 1'b1;
               end
               rank_wr[tway] = '1;
            end
         end
         default: ;
      endcase
      wr_set   = e_set;
      valid_wr = vrow_n;
      dirty_wr = drow_n;
      if (state_ff == sacl_pkg::ST_CLEAR) begin
         mem_we   = 1'b1;
         wr_set   = clr_ff[SB-1:0];
         valid_wr = '0;
         dirty_wr = '0;
         for (int w = 0; w < NW; w++) rank_wr[w] = WB'(w);
      end else if (state_ff != sacl_pkg::ST_EXEC) begin
         mem_we = 1'b0;
      end
      if (alloc) res[0] = 1'b0;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         sacl_pkg::ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (SB+1)'(sacl_pkg::NUM_SETS - 1)) state_in = sacl_pkg::ST_IDLE;
         end
         sacl_pkg::ST_IDLE: if (req_fire) state_in = sacl_pkg::ST_EXEC;
         sacl_pkg::ST_EXEC: state_in = sacl_pkg::ST_IDLE;
         default: state_in = sacl_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sacl_pkg::ST_CLEAR;
         clr_ff       <= '0;
         off_ff       <= 5'd4;
         walloc_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         // accept register writes
         if (csr_valid) begin
            if (csr_index == sacl_pkg::CSR_OFFSET_BITS) off_ff <= csr_data;
            else walloc_ff <= csr_data[0];
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         // commit result
         if (state_ff == sacl_pkg::ST_EXEC) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_tdata[1:0];
         addr_ff <= req_addr;
         offc_ff <= off_now;
      end
      if (state_ff == sacl_pkg::ST_EXEC) rsp_ff <= res;
   end
endmodule
